// ----- src/ogr_pkg.sv -----
// Shared constants, types and helper functions for the occupancy grid reprojection block.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package ogr_pkg;

    // Target store geometry
    localparam int MAX_DST_DIM = 256;
    localparam int MAX_SRC_DIM = 1024;
    localparam int COORD_W     = $clog2(MAX_DST_DIM);
    localparam int DIM_W       = COORD_W + 1;
    localparam int ADDR_W      = 2 * COORD_W;
    localparam int GRID_CELLS  = MAX_DST_DIM * MAX_DST_DIM;
    localparam int CELLS_W     = 2 * DIM_W;
    localparam int ROW_BASE_W  = COORD_W + DIM_W;

    // Field widths
    localparam int REQ_TYPE_W  = 2;
    localparam int SRC_IDX_W   = 10;
    localparam int VALUE_W     = 8;
    localparam int READ_IDX_W  = 16;
    localparam int STATUS_W    = 2;
    localparam int ORG_W       = 32;
    localparam int RES_W       = 31;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    // Arithmetic widths: products, offsets and the quotient search
    localparam int PROD_W      = SRC_IDX_W + 1 + RES_W;
    localparam int DIFF_W      = PROD_W + 2;
    localparam int REM_W       = DIFF_W - 1;
    localparam int DIVISOR_W   = RES_W + 1;
    localparam int QUO_W       = COORD_W + 1;
    localparam int DIV_STEPS   = QUO_W;
    localparam int STEP_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int DSH_W       = DIVISOR_W + COORD_W;

    // Command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    // Request type codes on the input channel (anything else is a read)
    localparam logic [REQ_TYPE_W-1:0] REQ_TYPE_CLEAR = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_TYPE_CELL  = 2'd1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_WRITTEN = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_READ    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_CLEARED = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SRC_ORIGIN_X = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SRC_ORIGIN_Y = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SRC_RES      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DST_ORIGIN_X = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DST_ORIGIN_Y = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DST_RES      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_DST_WIDTH    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_DST_HEIGHT   = 3'd7;

    // Configuration reset values
    localparam logic [RES_W-1:0] RES_RESET = 31'd3277;
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DST_DIM);

    // Occupancy values
    localparam logic signed [VALUE_W-1:0] OCC_THRESHOLD = 8'sd50;
    localparam logic signed [VALUE_W-1:0] VALUE_OCC     = 8'sd100;
    localparam logic signed [VALUE_W-1:0] VALUE_FREE    = 8'sd0;
    localparam logic signed [VALUE_W-1:0] VALUE_UNKNOWN = -8'sd1;

    typedef enum logic [1:0] {
        CELL_FREE,
        CELL_OCC,
        CELL_UNKNOWN
    } cell_code_t;

    typedef enum logic [1:0] {
        KIND_CLEAR,
        KIND_CELL,
        KIND_READ
    } req_kind_t;

    typedef enum logic [2:0] {
        BK_INIT_CLEAR,
        BK_IDLE,
        BK_CLEAR,
        BK_DIV,
        BK_READ,
        BK_EMIT
    } back_state_t;

    // Working configuration, saturated and ready for use
    typedef struct packed {
        logic [ORG_W-1:0]     so_x;
        logic [ORG_W-1:0]     so_y;
        logic [RES_W-1:0]     src_res;
        logic [ORG_W-1:0]     do_x;
        logic [ORG_W-1:0]     do_y;
        logic [DIVISOR_W-1:0] divisor;
        logic [DIM_W-1:0]     width;
        logic [DIM_W-1:0]     height;
    } cfg_t;

    // Classified command passed from the front end to the back end
    typedef struct packed {
        req_kind_t           kind;
        cell_code_t          code;
        logic                src_ok;
        logic [DIFF_W-1:0]   diff_x;
        logic [DIFF_W-1:0]   diff_y;
        logic [ADDR_W-1:0]   read_addr;
        logic                read_ok;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COORD_W-1:0]  dst_col;
        logic [COORD_W-1:0]  dst_row;
        logic [VALUE_W-1:0]  out_value;
    } result_t;

    // Map a raw occupancy value onto occupied, unknown or free
    function automatic cell_code_t classify(input logic signed [VALUE_W-1:0] raw);
        cell_code_t code;
        if (raw >= OCC_THRESHOLD) begin
            code = CELL_OCC;
        end
        else if (raw == VALUE_UNKNOWN) begin
            code = CELL_UNKNOWN;
        end
        else begin
            code = CELL_FREE;
        end
        return code;
    endfunction

    // Expand a stored code back to its occupancy value
    function automatic logic signed [VALUE_W-1:0] decode_cell(input cell_code_t code);
        logic signed [VALUE_W-1:0] value;
        unique case (code)
            CELL_FREE: value = VALUE_FREE;
            CELL_OCC:  value = VALUE_OCC;
            default:   value = VALUE_UNKNOWN;
        endcase
        return value;
    endfunction

endpackage

`default_nettype wire

// ----- src/ogr_if.sv -----
// Valid/ready channel interfaces for requests and results of the grid reprojection block.
// Depends on ogr_pkg for the field widths.
`default_nettype none

interface ogr_req_if;
    logic                                     valid;
    logic                                     ready;
    logic [ogr_pkg::REQ_TYPE_W-1:0]           req_type;
    logic [ogr_pkg::SRC_IDX_W-1:0]            src_col;
    logic [ogr_pkg::SRC_IDX_W-1:0]            src_row;
    logic signed [ogr_pkg::VALUE_W-1:0]       cell_value;
    logic [ogr_pkg::READ_IDX_W-1:0]           read_index;

    modport source (
        output valid, req_type, src_col, src_row, cell_value, read_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, src_col, src_row, cell_value, read_index,
        output ready
    );
endinterface

interface ogr_rsp_if;
    logic                                     valid;
    logic                                     ready;
    logic [ogr_pkg::STATUS_W-1:0]             status;
    logic [ogr_pkg::COORD_W-1:0]              dst_col;
    logic [ogr_pkg::COORD_W-1:0]              dst_row;
    logic signed [ogr_pkg::VALUE_W-1:0]       out_value;

    modport source (
        output valid, status, dst_col, dst_row, out_value,
        input  ready
    );
    modport sink (
        input  valid, status, dst_col, dst_row, out_value,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/ogr_front.sv -----
// Front end: accepts requests, classifies them and computes the doubled world offsets.
// Depends on ogr_pkg and ogr_req_if.
`default_nettype none

module ogr_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    ogr_req_if.sink             req,
    input  wire ogr_pkg::cfg_t  cfg,
    input  wire logic           init_done,
    output logic                push_valid,
    input  wire logic           push_ready,
    output ogr_pkg::cmd_t       push_data
);

    // Stage A: captured request
    logic                                a_valid_reg;
    ogr_pkg::req_kind_t                  a_kind_reg;
    ogr_pkg::cell_code_t                 a_code_reg;
    logic [ogr_pkg::SRC_IDX_W-1:0]       a_col_reg;
    logic [ogr_pkg::SRC_IDX_W-1:0]       a_row_reg;
    logic [ogr_pkg::READ_IDX_W-1:0]      a_ridx_reg;

    // Stage B: products and grid size
    logic                                b_valid_reg;
    ogr_pkg::req_kind_t                  b_kind_reg;
    ogr_pkg::cell_code_t                 b_code_reg;
    logic                                b_src_ok_reg;
    logic [ogr_pkg::PROD_W-1:0]          b_prod_x_reg;
    logic [ogr_pkg::PROD_W-1:0]          b_prod_y_reg;
    logic [ogr_pkg::READ_IDX_W-1:0]      b_ridx_reg;
    logic [ogr_pkg::CELLS_W-1:0]         b_cells_reg;

    logic                                accept;
    logic                                a_move;
    logic                                b_free;
    ogr_pkg::req_kind_t                  kind_next;
    logic [ogr_pkg::SRC_IDX_W:0]         odd_x;
    logic [ogr_pkg::SRC_IDX_W:0]         odd_y;
    logic [ogr_pkg::PROD_W-1:0]          prod_x;
    logic [ogr_pkg::PROD_W-1:0]          prod_y;
    logic [ogr_pkg::CELLS_W-1:0]         cells;
    logic                                src_ok;
    logic [ogr_pkg::DIFF_W-1:0]          twice_so_x;
    logic [ogr_pkg::DIFF_W-1:0]          twice_so_y;
    logic [ogr_pkg::DIFF_W-1:0]          twice_do_x;
    logic [ogr_pkg::DIFF_W-1:0]          twice_do_y;

    // Handshake: advance when the next stage is free
    assign b_free     = !b_valid_reg || push_ready;
    assign a_move     = a_valid_reg && b_free;
    assign req.ready  = (!a_valid_reg || b_free) && init_done;
    assign accept     = req.valid && req.ready;
    assign push_valid = b_valid_reg;

    // Decode the request type; unused codes read
    always_comb
    begin
        priority if (req.req_type == ogr_pkg::REQ_TYPE_CLEAR)
        begin
            kind_next = ogr_pkg::KIND_CLEAR;
        end
        else if (req.req_type == ogr_pkg::REQ_TYPE_CELL)
        begin
            kind_next = ogr_pkg::KIND_CELL;
        end
        else
        begin
            kind_next = ogr_pkg::KIND_READ;
        end
    end

    // Scaled cell centers: (2*index + 1) * src_resolution
    assign odd_x  = {a_col_reg, 1'b1};
    assign odd_y  = {a_row_reg, 1'b1};
    assign prod_x = ogr_pkg::PROD_W'(odd_x) * ogr_pkg::PROD_W'(cfg.src_res);
    assign prod_y = ogr_pkg::PROD_W'(odd_y) * ogr_pkg::PROD_W'(cfg.src_res);
    assign cells  = ogr_pkg::CELLS_W'(cfg.width) * ogr_pkg::CELLS_W'(cfg.height);
    assign src_ok = (32'(a_col_reg) < 32'(ogr_pkg::MAX_SRC_DIM))
                 && (32'(a_row_reg) < 32'(ogr_pkg::MAX_SRC_DIM));

    // Doubled origins, sign extended
    assign twice_so_x = {{(ogr_pkg::DIFF_W-ogr_pkg::ORG_W-1){cfg.so_x[ogr_pkg::ORG_W-1]}},
                         cfg.so_x, 1'b0};
    assign twice_so_y = {{(ogr_pkg::DIFF_W-ogr_pkg::ORG_W-1){cfg.so_y[ogr_pkg::ORG_W-1]}},
                         cfg.so_y, 1'b0};
    assign twice_do_x = {{(ogr_pkg::DIFF_W-ogr_pkg::ORG_W-1){cfg.do_x[ogr_pkg::ORG_W-1]}},
                         cfg.do_x, 1'b0};
    assign twice_do_y = {{(ogr_pkg::DIFF_W-ogr_pkg::ORG_W-1){cfg.do_y[ogr_pkg::ORG_W-1]}},
                         cfg.do_y, 1'b0};

    // Build the queue entry from stage B
    always_comb
    begin
        push_data.kind      = b_kind_reg;
        push_data.code      = b_code_reg;
        push_data.src_ok    = b_src_ok_reg;
        push_data.diff_x    = twice_so_x + ogr_pkg::DIFF_W'(b_prod_x_reg) - twice_do_x;
        push_data.diff_y    = twice_so_y + ogr_pkg::DIFF_W'(b_prod_y_reg) - twice_do_y;
        push_data.read_addr = ogr_pkg::ADDR_W'(b_ridx_reg);
        push_data.read_ok   = ogr_pkg::CELLS_W'(b_ridx_reg) < b_cells_reg;
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_move)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_move)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (push_ready)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_kind_reg <= kind_next;
            a_code_reg <= ogr_pkg::classify(req.cell_value);
            a_col_reg  <= req.src_col;
            a_row_reg  <= req.src_row;
            a_ridx_reg <= req.read_index;
        end
        if (a_move)
        begin
            b_kind_reg   <= a_kind_reg;
            b_code_reg   <= a_code_reg;
            b_src_ok_reg <= src_ok;
            b_prod_x_reg <= prod_x;
            b_prod_y_reg <= prod_y;
            b_ridx_reg   <= a_ridx_reg;
            b_cells_reg  <= cells;
        end
    end

endmodule

`default_nettype wire

// ----- src/ogr_fifo.sv -----
// Two-entry command queue between the front end and the back end.
// Depends on ogr_pkg for the command type and depth.
`default_nettype none

module ogr_fifo (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push_valid,
    output logic                         push_ready,
    input  wire ogr_pkg::cmd_t           push_data,
    output logic                         pop_valid,
    input  wire logic                    pop_ready,
    output ogr_pkg::cmd_t                pop_data,
    output logic [ogr_pkg::QLVL_W-1:0]   level
);

    ogr_pkg::cmd_t                entry_reg [ogr_pkg::QUEUE_DEPTH];
    logic [ogr_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [ogr_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [ogr_pkg::QLVL_W-1:0]   level_reg;
    logic                         push_fire;
    logic                         pop_fire;

    assign push_ready = level_reg != ogr_pkg::QLVL_W'(ogr_pkg::QUEUE_DEPTH);
    assign pop_valid  = level_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign level      = level_reg;
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= (wr_ptr_reg == ogr_pkg::QPTR_W'(ogr_pkg::QUEUE_DEPTH - 1))
                            ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= (rd_ptr_reg == ogr_pkg::QPTR_W'(ogr_pkg::QUEUE_DEPTH - 1))
                            ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({push_fire, pop_fire})
                2'b10:   level_reg <= level_reg + 1'b1;
                2'b01:   level_reg <= level_reg - 1'b1;
                default: level_reg <= level_reg;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/ogr_div.sv -----
// Restoring divider that finds the target cell index along one axis, one bit per cycle.
// Depends on ogr_pkg for the operand widths.
`default_nettype none

module ogr_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [ogr_pkg::REM_W-1:0]     dividend,
    input  wire logic [ogr_pkg::DIVISOR_W-1:0] divisor,
    output logic                               busy,
    output logic [ogr_pkg::QUO_W-1:0]          quotient
);

    logic [ogr_pkg::STEP_CNT_W-1:0] cnt_reg;
    logic [ogr_pkg::REM_W-1:0]      rem_reg;
    logic [ogr_pkg::DSH_W-1:0]      dsh_reg;
    logic [ogr_pkg::QUO_W-1:0]      quo_reg;
    logic                           fits;
    logic [ogr_pkg::REM_W-1:0]      rem_sub;

    // Trial subtract of the shifted divisor
    assign fits     = rem_reg >= ogr_pkg::REM_W'(dsh_reg);
    assign rem_sub  = rem_reg - ogr_pkg::REM_W'(dsh_reg);
    assign busy     = cnt_reg != '0;
    assign quotient = quo_reg;

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= ogr_pkg::STEP_CNT_W'(ogr_pkg::DIV_STEPS);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Shift in one quotient bit per step, top bit first
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dsh_reg <= {divisor, {ogr_pkg::COORD_W{1'b0}}};
            quo_reg <= '0;
        end
        else if (busy)
        begin
            if (fits)
            begin
                rem_reg <= rem_sub;
            end
            quo_reg <= {quo_reg[ogr_pkg::QUO_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

endmodule

`default_nettype wire

// ----- src/ogr_back.sv -----
// Back end: runs the per-axis dividers, owns the target grid store and the result register.
// Depends on ogr_pkg, ogr_rsp_if and ogr_div.
`default_nettype none

module ogr_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ogr_pkg::cfg_t  cfg,
    input  wire logic           pop_valid,
    output logic                pop_ready,
    input  wire ogr_pkg::cmd_t  pop_data,
    ogr_rsp_if.source           rsp,
    output logic                init_done
);

    ogr_pkg::cell_code_t            grid_mem [ogr_pkg::GRID_CELLS];

    ogr_pkg::back_state_t           state_reg;
    ogr_pkg::back_state_t           state_next;
    logic [ogr_pkg::ADDR_W-1:0]     sweep_reg;
    logic [ogr_pkg::ADDR_W-1:0]     sweep_next;
    ogr_pkg::cmd_t                  cmd_reg;
    ogr_pkg::result_t               res_reg;
    ogr_pkg::result_t               res_next;
    logic                           out_valid_reg;
    ogr_pkg::result_t               out_data_reg;
    ogr_pkg::cell_code_t            rd_data_reg;

    logic                           cmd_load;
    logic                           out_load;
    logic                           out_free;
    logic                           sweep_last;
    logic                           div_start;
    logic                           busy_x;
    logic                           busy_y;
    logic [ogr_pkg::QUO_W-1:0]      qx;
    logic [ogr_pkg::QUO_W-1:0]      qy;
    logic                           in_bounds;
    logic [ogr_pkg::ROW_BASE_W-1:0] row_base;
    logic [ogr_pkg::ADDR_W-1:0]     cell_addr;
    logic                           mem_we;
    logic [ogr_pkg::ADDR_W-1:0]     mem_waddr;
    ogr_pkg::cell_code_t            mem_wdata;
    logic                           mem_re;

    assign div_start = (state_reg == ogr_pkg::BK_IDLE) && pop_valid
                    && (pop_data.kind == ogr_pkg::KIND_CELL);

    ogr_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pop_data.diff_x[ogr_pkg::REM_W-1:0]),
        .divisor  (cfg.divisor),
        .busy     (busy_x),
        .quotient (qx)
    );

    ogr_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pop_data.diff_y[ogr_pkg::REM_W-1:0]),
        .divisor  (cfg.divisor),
        .busy     (busy_y),
        .quotient (qy)
    );

    assign init_done  = state_reg != ogr_pkg::BK_INIT_CLEAR;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign sweep_last = sweep_reg == ogr_pkg::ADDR_W'(ogr_pkg::GRID_CELLS - 1);

    // Target cell check and linear address
    assign in_bounds = cmd_reg.src_ok
                    && !cmd_reg.diff_x[ogr_pkg::DIFF_W-1]
                    && !cmd_reg.diff_y[ogr_pkg::DIFF_W-1]
                    && (qx < cfg.width)
                    && (qy < cfg.height);
    assign row_base  = ogr_pkg::ROW_BASE_W'(qy[ogr_pkg::COORD_W-1:0])
                     * ogr_pkg::ROW_BASE_W'(cfg.width);
    assign cell_addr = ogr_pkg::ADDR_W'(row_base
                     + ogr_pkg::ROW_BASE_W'(qx[ogr_pkg::COORD_W-1:0]));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ogr_pkg::BK_INIT_CLEAR:
            begin
                if (sweep_last)
                begin
                    state_next = ogr_pkg::BK_IDLE;
                end
            end
            ogr_pkg::BK_IDLE:
            begin
                if (pop_valid)
                begin
                    unique case (pop_data.kind)
                        ogr_pkg::KIND_CLEAR: state_next = ogr_pkg::BK_CLEAR;
                        ogr_pkg::KIND_CELL:  state_next = ogr_pkg::BK_DIV;
                        default:             state_next = ogr_pkg::BK_READ;
                    endcase
                end
            end
            ogr_pkg::BK_CLEAR:
            begin
                if (sweep_last)
                begin
                    state_next = ogr_pkg::BK_EMIT;
                end
            end
            ogr_pkg::BK_DIV:
            begin
                if (!busy_x && !busy_y)
                begin
                    state_next = ogr_pkg::BK_EMIT;
                end
            end
            ogr_pkg::BK_READ:
            begin
                state_next = ogr_pkg::BK_EMIT;
            end
            ogr_pkg::BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ogr_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = ogr_pkg::BK_IDLE;
            end
        endcase
    end

    // State outputs: store access, result staging, queue pop
    always_comb
    begin
        pop_ready  = 1'b0;
        cmd_load   = 1'b0;
        out_load   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = sweep_reg;
        mem_wdata  = ogr_pkg::CELL_UNKNOWN;
        mem_re     = 1'b0;
        sweep_next = sweep_reg;
        res_next   = res_reg;
        unique case (state_reg)
            ogr_pkg::BK_INIT_CLEAR:
            begin
                mem_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
            end
            ogr_pkg::BK_IDLE:
            begin
                pop_ready = 1'b1;
                cmd_load  = pop_valid;
                mem_re    = pop_valid && (pop_data.kind == ogr_pkg::KIND_READ);
            end
            ogr_pkg::BK_CLEAR:
            begin
                mem_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                res_next.status    = ogr_pkg::STATUS_CLEARED;
                res_next.dst_col   = '0;
                res_next.dst_row   = '0;
                res_next.out_value = ogr_pkg::VALUE_UNKNOWN;
            end
            ogr_pkg::BK_DIV:
            begin
                // Write the cell once both quotients are in
                if (!busy_x && !busy_y)
                begin
                    mem_we    = in_bounds;
                    mem_waddr = cell_addr;
                    mem_wdata = cmd_reg.code;
                    res_next.out_value = ogr_pkg::decode_cell(cmd_reg.code);
                    if (in_bounds)
                    begin
                        res_next.status  = ogr_pkg::STATUS_WRITTEN;
                        res_next.dst_col = qx[ogr_pkg::COORD_W-1:0];
                        res_next.dst_row = qy[ogr_pkg::COORD_W-1:0];
                    end
                    else
                    begin
                        res_next.status  = ogr_pkg::STATUS_DROPPED;
                        res_next.dst_col = '0;
                        res_next.dst_row = '0;
                    end
                end
            end
            ogr_pkg::BK_READ:
            begin
                res_next.status    = ogr_pkg::STATUS_READ;
                res_next.dst_col   = '0;
                res_next.dst_row   = '0;
                res_next.out_value = cmd_reg.read_ok ? ogr_pkg::decode_cell(rd_data_reg)
                                                     : ogr_pkg::VALUE_UNKNOWN;
            end
            ogr_pkg::BK_EMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
                pop_ready = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ogr_pkg::BK_INIT_CLEAR;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Command, staged result and output payload
    always_ff @(posedge clk)
    begin
        if (cmd_load)
        begin
            cmd_reg <= pop_data;
        end
        res_reg <= res_next;
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    // Target grid store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= grid_mem[pop_data.read_addr];
        end
    end

    // Drive the result channel
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_data_reg.status;
    assign rsp.dst_col   = out_data_reg.dst_col;
    assign rsp.dst_row   = out_data_reg.dst_row;
    assign rsp.out_value = out_data_reg.out_value;

endmodule

`default_nettype wire

// ----- src/occupancy_grid_reproject.sv -----
// Top level of the occupancy grid reprojection block: configuration registers and wiring.
// Depends on ogr_pkg, ogr_if, ogr_front, ogr_fifo and ogr_back.
//
//   channel  direction  handshake             payload
//   req      in         req.valid/req.ready   req_type, src_col, src_row, cell_value, read_index
//   rsp      out        rsp.valid/rsp.ready   status, dst_col, dst_row, out_value
//   cfg      in         cfg_we                cfg_index, cfg_data
//
// A source cell waits in the back end for the two 9-step restoring dividers that
// run side by side; a read passes through the BK_READ and BK_EMIT states.
// A clear request sweeps the 65536-entry store, one entry a cycle.
// After reset the same sweep runs with req.ready held low.
// A two-entry queue and a result register let each side stall on its own.
`default_nettype none

module occupancy_grid_reproject (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    ogr_req_if.sink                                  req,
    ogr_rsp_if.source                                rsp,
    input  wire logic                                cfg_we,
    input  wire logic [ogr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [ogr_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [ogr_pkg::ORG_W-1:0]  so_x_reg;
    logic [ogr_pkg::ORG_W-1:0]  so_y_reg;
    logic [ogr_pkg::RES_W-1:0]  src_res_reg;
    logic [ogr_pkg::ORG_W-1:0]  do_x_reg;
    logic [ogr_pkg::ORG_W-1:0]  do_y_reg;
    logic [ogr_pkg::RES_W-1:0]  dst_res_reg;
    logic [ogr_pkg::DIM_W-1:0]  width_reg;
    logic [ogr_pkg::DIM_W-1:0]  height_reg;

    ogr_pkg::cfg_t              cfg;
    logic                       init_done;
    logic                       push_valid;
    logic                       push_ready;
    ogr_pkg::cmd_t              push_data;
    logic                       pop_valid;
    logic                       pop_ready;
    ogr_pkg::cmd_t              pop_data;
    logic [ogr_pkg::QLVL_W-1:0] q_level;

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            so_x_reg    <= '0;
            so_y_reg    <= '0;
            src_res_reg <= ogr_pkg::RES_RESET;
            do_x_reg    <= '0;
            do_y_reg    <= '0;
            dst_res_reg <= ogr_pkg::RES_RESET;
            width_reg   <= ogr_pkg::DIM_RESET;
            height_reg  <= ogr_pkg::DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ogr_pkg::CFG_SRC_ORIGIN_X: so_x_reg    <= cfg_data;
                ogr_pkg::CFG_SRC_ORIGIN_Y: so_y_reg    <= cfg_data;
                ogr_pkg::CFG_SRC_RES:      src_res_reg <= cfg_data[ogr_pkg::RES_W-1:0];
                ogr_pkg::CFG_DST_ORIGIN_X: do_x_reg    <= cfg_data;
                ogr_pkg::CFG_DST_ORIGIN_Y: do_y_reg    <= cfg_data;
                ogr_pkg::CFG_DST_RES:      dst_res_reg <= cfg_data[ogr_pkg::RES_W-1:0];
                ogr_pkg::CFG_DST_WIDTH:    width_reg   <= cfg_data[ogr_pkg::DIM_W-1:0];
                ogr_pkg::CFG_DST_HEIGHT:   height_reg  <= cfg_data[ogr_pkg::DIM_W-1:0];
                default:                   so_x_reg    <= so_x_reg;
            endcase
        end
    end

    // Working configuration: saturate dimensions, zero resolution acts as one step
    always_comb
    begin
        cfg.so_x    = so_x_reg;
        cfg.so_y    = so_y_reg;
        cfg.src_res = src_res_reg;
        cfg.do_x    = do_x_reg;
        cfg.do_y    = do_y_reg;
        cfg.divisor = (dst_res_reg == '0) ? ogr_pkg::DIVISOR_W'(2)
                                          : {dst_res_reg, 1'b0};
        cfg.width   = (width_reg > ogr_pkg::DIM_W'(ogr_pkg::MAX_DST_DIM))
                    ? ogr_pkg::DIM_W'(ogr_pkg::MAX_DST_DIM) : width_reg;
        cfg.height  = (height_reg > ogr_pkg::DIM_W'(ogr_pkg::MAX_DST_DIM))
                    ? ogr_pkg::DIM_W'(ogr_pkg::MAX_DST_DIM) : height_reg;
    end

    ogr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .init_done  (init_done),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    ogr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .level      (q_level)
    );

    ogr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .rsp        (rsp),
        .init_done  (init_done)
    );

`ifndef ASSERT_OFF
    // No request enters while the store is still being swept after reset
    a_no_accept_during_init: assert property (@(posedge clk) disable iff (!rst_n)
        !init_done |-> !(req.valid && req.ready))
        else $error("request accepted during initial store sweep");

    // The initial sweep runs once and never comes back
    a_init_stays_done: assert property (@(posedge clk) disable iff (!rst_n)
        init_done |=> init_done)
        else $error("initial sweep restarted");

    // The command queue never holds more than its depth
    a_queue_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= ogr_pkg::QLVL_W'(ogr_pkg::QUEUE_DEPTH))
        else $error("command queue overfilled");
`endif

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for occupancy_grid_reproject: directed and random requests,
// a scoreboard class that predicts every result and compares it field by field.
// Depends on ogr_pkg, ogr_if and the block's RTL.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Read request codes (the package names only clear and cell)
    localparam logic [ogr_pkg::REQ_TYPE_W-1:0] REQ_TYPE_READ     = 2'd2;
    localparam logic [ogr_pkg::REQ_TYPE_W-1:0] REQ_TYPE_READ_ALT = 2'd3;

    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int STEADY_PHASE    = 6;
    localparam int TAIL_CYCLES     = 20;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int PRINT_CAP       = 40;

    typedef struct {
        logic [ogr_pkg::CFG_DATA_W-1:0] so_x;
        logic [ogr_pkg::CFG_DATA_W-1:0] so_y;
        logic [ogr_pkg::CFG_DATA_W-1:0] s_res;
        logic [ogr_pkg::CFG_DATA_W-1:0] do_x;
        logic [ogr_pkg::CFG_DATA_W-1:0] do_y;
        logic [ogr_pkg::CFG_DATA_W-1:0] d_res;
        logic [ogr_pkg::CFG_DATA_W-1:0] width;
        logic [ogr_pkg::CFG_DATA_W-1:0] height;
    } grid_setup_t;

    // Predicts the target store and the result of every accepted transaction
    class grid_scoreboard;
        logic [ogr_pkg::ORG_W-1:0] so_x, so_y, do_x, do_y;
        logic [ogr_pkg::RES_W-1:0] s_res, d_res;
        logic [ogr_pkg::DIM_W-1:0] w_raw, h_raw;
        ogr_pkg::cell_code_t       grid [ogr_pkg::GRID_CELLS];
        ogr_pkg::result_t          expected [$];
        int unsigned               touched [$];
        int                        mismatches;

        function new();
            so_x = '0;
            so_y = '0;
            do_x = '0;
            do_y = '0;
            s_res = ogr_pkg::RES_RESET;
            d_res = ogr_pkg::RES_RESET;
            w_raw = ogr_pkg::DIM_RESET;
            h_raw = ogr_pkg::DIM_RESET;
            mismatches = 0;
            foreach (grid[i]) grid[i] = ogr_pkg::CELL_UNKNOWN;
        endfunction

        function int unsigned clip_dim(logic [ogr_pkg::DIM_W-1:0] d);
            return (d > ogr_pkg::MAX_DST_DIM) ? ogr_pkg::MAX_DST_DIM : int'(d);
        endfunction

        function int unsigned cells_in_use();
            return clip_dim(w_raw) * clip_dim(h_raw);
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function ogr_pkg::cell_code_t grade_raw(logic signed [ogr_pkg::VALUE_W-1:0] raw);
            if (raw >= ogr_pkg::OCC_THRESHOLD)
                return ogr_pkg::CELL_OCC;
            if (raw == ogr_pkg::VALUE_UNKNOWN)
                return ogr_pkg::CELL_UNKNOWN;
            return ogr_pkg::CELL_FREE;
        endfunction

        function logic [ogr_pkg::VALUE_W-1:0] code_value(ogr_pkg::cell_code_t code);
            case (code)
                ogr_pkg::CELL_OCC:  return ogr_pkg::VALUE_OCC;
                ogr_pkg::CELL_FREE: return ogr_pkg::VALUE_FREE;
                default:            return ogr_pkg::VALUE_UNKNOWN;
            endcase
        endfunction

        // Exact cell index on one axis, worked at twice the scale to keep the half cell
        function bit project_axis(logic [ogr_pkg::ORG_W-1:0] s_org,
                                  logic [ogr_pkg::SRC_IDX_W-1:0] idx,
                                  logic [ogr_pkg::ORG_W-1:0] d_org, int unsigned limit,
                                  output int unsigned slot);
            longint twice_pos, diff, divisor, quo;
            twice_pos = 2 * longint'($signed(s_org))
                        + (2 * longint'(idx) + 1) * longint'(s_res);
            diff = twice_pos - 2 * longint'($signed(d_org));
            divisor = 2 * ((d_res == '0) ? longint'(1) : longint'(d_res));
            slot = 0;
            if (diff < 0)
                return 1'b0;
            quo = diff / divisor;
            if (quo >= longint'(limit))
                return 1'b0;
            slot = int'(quo);
            return 1'b1;
        endfunction

        function void write_reg(logic [ogr_pkg::CFG_INDEX_W-1:0] idx,
                                logic [ogr_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                ogr_pkg::CFG_SRC_ORIGIN_X: so_x = data;
                ogr_pkg::CFG_SRC_ORIGIN_Y: so_y = data;
                ogr_pkg::CFG_SRC_RES:      s_res = data[ogr_pkg::RES_W-1:0];
                ogr_pkg::CFG_DST_ORIGIN_X: do_x = data;
                ogr_pkg::CFG_DST_ORIGIN_Y: do_y = data;
                ogr_pkg::CFG_DST_RES:      d_res = data[ogr_pkg::RES_W-1:0];
                ogr_pkg::CFG_DST_WIDTH:    w_raw = data[ogr_pkg::DIM_W-1:0];
                ogr_pkg::CFG_DST_HEIGHT:   h_raw = data[ogr_pkg::DIM_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic [ogr_pkg::REQ_TYPE_W-1:0] kind,
                                   logic [ogr_pkg::SRC_IDX_W-1:0] col,
                                   logic [ogr_pkg::SRC_IDX_W-1:0] row,
                                   logic signed [ogr_pkg::VALUE_W-1:0] raw,
                                   logic [ogr_pkg::READ_IDX_W-1:0] ridx);
            ogr_pkg::result_t    r;
            int unsigned         w, h, cx, cy, addr;
            ogr_pkg::cell_code_t code;
            r = '0;
            w = clip_dim(w_raw);
            h = clip_dim(h_raw);
            if (kind == ogr_pkg::REQ_TYPE_CLEAR)
            begin
                foreach (grid[i]) grid[i] = ogr_pkg::CELL_UNKNOWN;
                r.status = ogr_pkg::STATUS_CLEARED;
                r.out_value = ogr_pkg::VALUE_UNKNOWN;
            end
            else if (kind == ogr_pkg::REQ_TYPE_CELL)
            begin
                code = grade_raw(raw);
                r.out_value = code_value(code);
                if (col < ogr_pkg::MAX_SRC_DIM && row < ogr_pkg::MAX_SRC_DIM
                    && project_axis(so_x, col, do_x, w, cx)
                    && project_axis(so_y, row, do_y, h, cy))
                begin
                    addr = cy * w + cx;
                    grid[addr] = code;
                    r.status = ogr_pkg::STATUS_WRITTEN;
                    r.dst_col = ogr_pkg::COORD_W'(cx);
                    r.dst_row = ogr_pkg::COORD_W'(cy);
                    // Remember recent writes so reads can revisit them
                    touched.push_back(addr);
                    if (touched.size() > 64)
                        void'(touched.pop_front());
                end
                else
                begin
                    r.status = ogr_pkg::STATUS_DROPPED;
                end
            end
            else
            begin
                r.status = ogr_pkg::STATUS_READ;
                r.out_value = (ridx < w * h) ? code_value(grid[ridx])
                                             : ogr_pkg::VALUE_UNKNOWN;
            end
            expected.push_back(r);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < PRINT_CAP)
                $display("[%0t] ERROR result check: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [ogr_pkg::STATUS_W-1:0] status,
                          logic [ogr_pkg::COORD_W-1:0] col,
                          logic [ogr_pkg::COORD_W-1:0] row,
                          logic [ogr_pkg::VALUE_W-1:0] value);
            ogr_pkg::result_t want;
            if (expected.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing outstanding, status %0d",
                                          status));
                return;
            end
            want = expected.pop_front();
            if (status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d", status, want.status));
            if (col !== want.dst_col)
                report_mismatch($sformatf("dst_col got %0d want %0d", col, want.dst_col));
            if (row !== want.dst_row)
                report_mismatch($sformatf("dst_row got %0d want %0d", row, want.dst_row));
            if (value !== want.out_value)
                report_mismatch($sformatf("out_value got %0d want %0d",
                                          $signed(value), $signed(want.out_value)));
        endtask
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we;
    logic [ogr_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [ogr_pkg::CFG_DATA_W-1:0]  cfg_data;
    bit                              steady = 1'b0;
    int                              clears_left = 3;
    int unsigned                     cycles = 0;

    grid_scoreboard sb = new();

    ogr_req_if req_ch();
    ogr_rsp_if rsp_ch();

    occupancy_grid_reproject DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Stall the result side at random, except in the steady phase
    always @(posedge clk)
    begin
        rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 28);
    end

    // Observe register writes and both channels at each edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.status, rsp_ch.dst_col, rsp_ch.dst_row,
                                rsp_ch.out_value);
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.req_type, req_ch.src_col, req_ch.src_row,
                                req_ch.cell_value, req_ch.read_index);
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Present one transaction after a random gap and hold it until accepted
    task automatic send_request(logic [ogr_pkg::REQ_TYPE_W-1:0] kind,
                                logic [ogr_pkg::SRC_IDX_W-1:0] col,
                                logic [ogr_pkg::SRC_IDX_W-1:0] row,
                                logic [ogr_pkg::VALUE_W-1:0] raw,
                                logic [ogr_pkg::READ_IDX_W-1:0] ridx);
        while (!steady && $urandom_range(0, 99) < 28)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.src_col    <= col;
        req_ch.src_row    <= row;
        req_ch.cell_value <= raw;
        req_ch.read_index <= ridx;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_cell(logic [ogr_pkg::SRC_IDX_W-1:0] col,
                             logic [ogr_pkg::SRC_IDX_W-1:0] row,
                             logic [ogr_pkg::VALUE_W-1:0] raw);
        send_request(ogr_pkg::REQ_TYPE_CELL, col, row, raw, ogr_pkg::READ_IDX_W'($urandom));
    endtask

    task automatic send_read(logic [ogr_pkg::REQ_TYPE_W-1:0] kind,
                             logic [ogr_pkg::READ_IDX_W-1:0] ridx);
        send_request(kind, ogr_pkg::SRC_IDX_W'($urandom), ogr_pkg::SRC_IDX_W'($urandom),
                     ogr_pkg::VALUE_W'($urandom), ridx);
    endtask

    // Drop valid and hold until every outstanding result has come back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic set_register(logic [ogr_pkg::CFG_INDEX_W-1:0] idx,
                                logic [ogr_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic apply_settings(grid_setup_t s);
        set_register(ogr_pkg::CFG_SRC_ORIGIN_X, s.so_x);
        set_register(ogr_pkg::CFG_SRC_ORIGIN_Y, s.so_y);
        set_register(ogr_pkg::CFG_SRC_RES, s.s_res);
        set_register(ogr_pkg::CFG_DST_ORIGIN_X, s.do_x);
        set_register(ogr_pkg::CFG_DST_ORIGIN_Y, s.do_y);
        set_register(ogr_pkg::CFG_DST_RES, s.d_res);
        set_register(ogr_pkg::CFG_DST_WIDTH, s.width);
        set_register(ogr_pkg::CFG_DST_HEIGHT, s.height);
        cfg_we <= 1'b0;
    endtask

    // Fixed corner settings first, then random geometry near the source grid
    function automatic grid_setup_t phase_setup(int p);
        grid_setup_t s;
        int          org;
        int unsigned sres, dres;
        case (p)
            // extreme origins and resolutions; oversized dimensions saturate
            1: s = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
            // zero width drops every cell
            2: s = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h100};
            // zero target resolution acts as one step; single row
            3: s = '{32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'h100, 32'd1};
            // target origin above the first source cells
            4: s = '{32'd0, 32'd0, 32'd3277, 32'd52432, 32'd52432, 32'd3277, 32'd300, 32'd200};
            default:
            begin
                sres = $urandom_range(1, 1 << 20);
                dres = $urandom_range(sres / 2 + 1, sres * 2);
                s.s_res = sres;
                s.d_res = dres;
                org = int'($urandom_range(0, 1 << 29)) - (1 << 28);
                s.so_x = org;
                s.do_x = org + int'($urandom_range(0, 4 * dres)) - int'(3 * dres);
                org = int'($urandom_range(0, 1 << 29)) - (1 << 28);
                s.so_y = org;
                s.do_y = org + int'($urandom_range(0, 4 * dres)) - int'(3 * dres);
                s.width  = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 256);
                s.height = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 256);
            end
        endcase
        return s;
    endfunction

    // Mostly cells that land in the target, reads of recent writes, rare clears
    task automatic random_request();
        int unsigned                    pick, span;
        logic [ogr_pkg::SRC_IDX_W-1:0]  col, row;
        logic [ogr_pkg::VALUE_W-1:0]    raw;
        logic [ogr_pkg::READ_IDX_W-1:0] ridx;
        pick = $urandom_range(0, 999);
        if (pick < 8 && clears_left > 0)
        begin
            clears_left--;
            send_request(ogr_pkg::REQ_TYPE_CLEAR, ogr_pkg::SRC_IDX_W'($urandom),
                         ogr_pkg::SRC_IDX_W'($urandom), ogr_pkg::VALUE_W'($urandom),
                         ogr_pkg::READ_IDX_W'($urandom));
        end
        else if (pick < 600)
        begin
            col = ($urandom_range(0, 99) < 85) ? ogr_pkg::SRC_IDX_W'($urandom_range(0, 300))
                                               : ogr_pkg::SRC_IDX_W'($urandom);
            row = ($urandom_range(0, 99) < 85) ? ogr_pkg::SRC_IDX_W'($urandom_range(0, 300))
                                               : ogr_pkg::SRC_IDX_W'($urandom);
            case ($urandom_range(0, 9))
                0, 1, 2: raw = ogr_pkg::VALUE_UNKNOWN;
                3, 4:    raw = ogr_pkg::VALUE_W'($urandom_range(46, 54));
                default: raw = ogr_pkg::VALUE_W'($urandom);
            endcase
            send_cell(col, row, raw);
        end
        else
        begin
            span = sb.cells_in_use();
            pick = $urandom_range(0, 9);
            if (pick < 6 && sb.touched.size() > 0)
                ridx = ogr_pkg::READ_IDX_W'(sb.touched[$urandom_range(0,
                                                       sb.touched.size() - 1)]);
            else if (pick < 9 && span > 0)
                ridx = ogr_pkg::READ_IDX_W'($urandom_range(0, span - 1));
            else
                ridx = ogr_pkg::READ_IDX_W'($urandom);
            send_read(($urandom_range(0, 99) < 85) ? REQ_TYPE_READ : REQ_TYPE_READ_ALT, ridx);
        end
    endtask

    initial
    begin
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= ogr_pkg::REQ_TYPE_CLEAR;
        req_ch.src_col    <= '0;
        req_ch.src_row    <= '0;
        req_ch.cell_value <= '0;
        req_ch.read_index <= '0;
        cfg_we            <= 1'b0;
        cfg_index         <= ogr_pkg::CFG_SRC_ORIGIN_X;
        cfg_data          <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on the reset geometry: one target cell per source cell
        send_read(REQ_TYPE_READ, 16'd0);
        send_read(REQ_TYPE_READ_ALT, 16'hFFFF);
        send_cell(10'd0, 10'd0, 8'sd50);
        send_cell(10'd255, 10'd255, 8'sd49);
        send_cell(10'd256, 10'd3, 8'sd100);
        send_cell(10'd1023, 10'd1023, ogr_pkg::VALUE_UNKNOWN);
        send_cell(10'd5, 10'd7, 8'h80);
        send_cell(10'd6, 10'd7, 8'sd127);
        send_cell(10'd7, 10'd7, ogr_pkg::VALUE_UNKNOWN);
        send_cell(10'd8, 10'd7, -8'sd2);
        send_read(REQ_TYPE_READ, 16'd0);
        send_read(REQ_TYPE_READ, 16'hFFFF);
        send_read(REQ_TYPE_READ_ALT, 16'd1798);
        send_read(REQ_TYPE_READ, 16'd1799);
        send_request(ogr_pkg::REQ_TYPE_CLEAR, 10'h3FF, 10'h3FF, 8'hFF, 16'hFFFF);
        send_read(REQ_TYPE_READ, 16'd0);
        send_read(REQ_TYPE_READ, 16'd1798);

        // Random phases, each on its own geometry
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                wait_drained();
                apply_settings(phase_setup(p));
            end
            steady = (p == STEADY_PHASE);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // hold off the sender until the block has emptied
                if (p[0] && n == ITEMS_PER_PHASE / 2)
                    wait_drained();
                random_request();
            end
        end
        steady = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
src/ogr_pkg.sv
src/ogr_if.sv
src/ogr_front.sv
src/ogr_fifo.sv
src/ogr_div.sv
src/ogr_back.sv
src/occupancy_grid_reproject.sv
dv/testbench.sv
